@@ src/dcwe_pkg.sv @@
// shared types, widths and constants of the dctcp window estimator
package dcwe_pkg;

    // field and state widths
    localparam int WIN_W     = 32;
    localparam int CNT_W     = 27;
    localparam int ALPHA_W   = 17;
    localparam int MSS_W     = 14;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = WIN_W + MUL_B_W;
    localparam int QUO_W     = 17;
    localparam int STEP_W    = 5;
    localparam int ALPHA_SUM_W = ALPHA_W + 4;

    // fixed values
    localparam logic [CNT_W-1:0]   CNT_MAX        = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'h10000;
    localparam logic [WIN_W-1:0]   LAST_WIN_RESET = 32'd3000;
    localparam logic [MSS_W-1:0]   MSS_RESET      = 14'd1500;
    localparam logic [ALPHA_W:0]   CUT_BASE       = 18'h20000;
    localparam logic [STEP_W-1:0]  MUL_STEPS      = 5'd17;
    localparam logic [STEP_W-1:0]  DIV_STEPS      = 5'd17;

    // request codes
    localparam logic REQ_ACK  = 1'b0;
    localparam logic REQ_DROP = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic             ece_flag;
        logic [WIN_W-1:0] cwnd_in;
        logic [WIN_W-1:0] ssthresh_in;
    } t_req;

    typedef struct packed {
        logic               [WIN_W-1:0] cwnd_out;
        logic               [WIN_W-1:0] ssthresh_out;
        logic                           window_update;
        logic             [ALPHA_W-1:0] alpha_out;
    } t_rsp;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP_GO,
        S_CMP_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CUT_GO,
        S_CUT_WAIT,
        S_EMIT
    } t_state;

endpackage

@@ src/dctcp_window_estimator.sv @@
// top level of the dctcp window estimator: control, state and result register
//
//  channel  direction  handshake            payload
//  request  in         i_valid / o_ready    i_req  (dcwe_pkg::t_req)
//  result   out        o_valid / i_ready    o_rsp  (dcwe_pkg::t_rsp)
//  config   in         i_cfg_we             i_cfg_data (mss, 14 bits)
//
// drop: accept goes straight to the emit state, then to the result register. ack inside a
// window: the 17-step serial multiply of acked count by mss. ack at window end: that
// multiply, the 17-step q16 division and, when the new alpha is nonzero, a second
// 17-step multiply for the window cut, all through single-bit serial units.
// one item is worked at a time; a new item is taken while the last result
// still waits in the output register, and a finished item holds only when
// that register is still full. reset is synchronous, with no clearing pass.
module dctcp_window_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  dcwe_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output dcwe_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [dcwe_pkg::MSS_W-1:0]    i_cfg_data
);

    dcwe_pkg::t_state r_state, n_state;

    // estimator state
    logic [dcwe_pkg::MSS_W-1:0]   r_mss;
    logic [dcwe_pkg::CNT_W-1:0]   r_acked, n_acked;
    logic [dcwe_pkg::CNT_W-1:0]   r_marked, n_marked;
    logic [dcwe_pkg::ALPHA_W-1:0] r_alpha, n_alpha;
    logic [dcwe_pkg::WIN_W-1:0]   r_last_win, n_last_win;

    // working item
    logic [dcwe_pkg::WIN_W-1:0]   r_cwnd, n_cwnd;
    logic [dcwe_pkg::WIN_W-1:0]   r_ssth, n_ssth;
    logic                         r_upd, n_upd;

    // result register
    logic                         r_out_valid, n_out_valid;
    dcwe_pkg::t_rsp               r_out, n_out;

    // serial units
    logic                           w_mul_start;
    logic [dcwe_pkg::WIN_W-1:0]     w_mul_a;
    logic [dcwe_pkg::MUL_B_W-1:0]   w_mul_b;
    dcwe_pkg::t_mul_rsp             w_mul;
    logic                           w_div_start;
    dcwe_pkg::t_div_rsp             w_div;

    logic                             w_accept;
    logic                             w_emit;
    logic                             w_win_end;
    logic [dcwe_pkg::CNT_W-1:0]       w_acked_inc;
    logic [dcwe_pkg::CNT_W-1:0]       w_marked_inc;
    logic [dcwe_pkg::WIN_W-1:0]       w_half;
    logic [dcwe_pkg::WIN_W-1:0]       w_two_mss;
    logic [dcwe_pkg::ALPHA_SUM_W-1:0] w_alpha_sum;
    logic [dcwe_pkg::ALPHA_W-1:0]     w_alpha_new;
    logic [dcwe_pkg::WIN_W-1:0]       w_cut;
    logic [dcwe_pkg::WIN_W-1:0]       w_cut_floor;

    assign o_ready  = (r_state == dcwe_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_emit   = (r_state == dcwe_pkg::S_EMIT) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    // saturating counters and drop threshold
    assign w_acked_inc  = (r_acked == dcwe_pkg::CNT_MAX) ? r_acked : r_acked + 1'b1;
    assign w_marked_inc = (r_marked == dcwe_pkg::CNT_MAX) ? r_marked : r_marked + 1'b1;
    assign w_half       = {1'b0, i_req.cwnd_in[dcwe_pkg::WIN_W-1:1]};
    assign w_two_mss    = dcwe_pkg::WIN_W'({r_mss, 1'b0});

    // window end: acked * mss reached the last window
    assign w_win_end = (w_mul.prod >= dcwe_pkg::PROD_W'(r_last_win));

    // alpha = (15 * alpha + f) / 16, clamped to one
    assign w_alpha_sum = {r_alpha, 4'b0000} - dcwe_pkg::ALPHA_SUM_W'(r_alpha)
                       + dcwe_pkg::ALPHA_SUM_W'(w_div.quo);
    assign w_alpha_new = (w_alpha_sum[dcwe_pkg::ALPHA_SUM_W-1:4] > dcwe_pkg::ALPHA_ONE)
                       ? dcwe_pkg::ALPHA_ONE : w_alpha_sum[dcwe_pkg::ALPHA_SUM_W-1:4];

    // window cut result with the one-mss floor
    assign w_cut       = w_mul.prod[dcwe_pkg::PROD_W-1:dcwe_pkg::MUL_B_W];
    assign w_cut_floor = (w_cut < dcwe_pkg::WIN_W'(r_mss)) ? dcwe_pkg::WIN_W'(r_mss) : w_cut;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcwe_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.req_type == dcwe_pkg::REQ_DROP)
                            ? dcwe_pkg::S_EMIT : dcwe_pkg::S_CMP_GO;
                end
            end
            dcwe_pkg::S_CMP_GO: begin
                n_state = dcwe_pkg::S_CMP_WAIT;
            end
            dcwe_pkg::S_CMP_WAIT: begin
                if (w_mul.done) begin
                    n_state = w_win_end ? dcwe_pkg::S_DIV_GO : dcwe_pkg::S_EMIT;
                end
            end
            dcwe_pkg::S_DIV_GO: begin
                n_state = dcwe_pkg::S_DIV_WAIT;
            end
            dcwe_pkg::S_DIV_WAIT: begin
                if (w_div.done) begin
                    n_state = (w_alpha_new != '0) ? dcwe_pkg::S_CUT_GO : dcwe_pkg::S_EMIT;
                end
            end
            dcwe_pkg::S_CUT_GO: begin
                n_state = dcwe_pkg::S_CUT_WAIT;
            end
            dcwe_pkg::S_CUT_WAIT: begin
                if (w_mul.done) begin
                    n_state = dcwe_pkg::S_EMIT;
                end
            end
            dcwe_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_state = dcwe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcwe_pkg::S_IDLE;
            end
        endcase
    end

    // unit starts and operands
    always_comb begin
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = r_cwnd;
        w_mul_b     = dcwe_pkg::MUL_B_W'(dcwe_pkg::CUT_BASE
                                          - (dcwe_pkg::ALPHA_W + 1)'(r_alpha));
        case (r_state)
            dcwe_pkg::S_CMP_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = dcwe_pkg::WIN_W'(r_acked);
                w_mul_b     = dcwe_pkg::MUL_B_W'(r_mss);
            end
            dcwe_pkg::S_DIV_GO: begin
                w_div_start = 1'b1;
            end
            dcwe_pkg::S_CUT_GO: begin
                w_mul_start = 1'b1;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // estimator state and working item
    always_comb begin
        n_acked     = r_acked;
        n_marked    = r_marked;
        n_alpha     = r_alpha;
        n_last_win  = r_last_win;
        n_cwnd      = r_cwnd;
        n_ssth      = r_ssth;
        n_upd       = r_upd;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        case (r_state)
            dcwe_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cwnd = i_req.cwnd_in;
                    n_ssth = i_req.ssthresh_in;
                    n_upd  = 1'b0;
                    if (i_req.req_type == dcwe_pkg::REQ_DROP) begin
                        n_acked    = '0;
                        n_marked   = '0;
                        n_last_win = i_req.cwnd_in;
                        n_ssth     = (w_half > w_two_mss) ? w_half : w_two_mss;
                    end else begin
                        n_acked = w_acked_inc;
                        if (i_req.ece_flag) begin
                            n_marked = w_marked_inc;
                            if (i_req.ssthresh_in > i_req.cwnd_in) begin
                                n_ssth = i_req.cwnd_in;
                            end
                        end
                    end
                end
            end
            dcwe_pkg::S_DIV_WAIT: begin
                if (w_div.done) begin
                    n_alpha  = w_alpha_new;
                    n_acked  = '0;
                    n_marked = '0;
                    n_upd    = 1'b1;
                    if (w_alpha_new == '0) begin
                        n_last_win = r_cwnd;
                    end
                end
            end
            dcwe_pkg::S_CUT_WAIT: begin
                if (w_mul.done) begin
                    n_cwnd     = w_cut_floor;
                    n_ssth     = w_cut_floor;
                    n_last_win = w_cut_floor;
                end
            end
            dcwe_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_out_valid         = 1'b1;
                    n_out.cwnd_out      = r_cwnd;
                    n_out.ssthresh_out  = r_ssth;
                    n_out.window_update = r_upd;
                    n_out.alpha_out     = r_alpha;
                end
            end
            default: begin
                n_upd = r_upd;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcwe_pkg::S_IDLE;
            r_mss       <= dcwe_pkg::MSS_RESET;
            r_acked     <= '0;
            r_marked    <= '0;
            r_alpha     <= '0;
            r_last_win  <= dcwe_pkg::LAST_WIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_mss <= i_cfg_data;
            end
            r_acked     <= n_acked;
            r_marked    <= n_marked;
            r_alpha     <= n_alpha;
            r_last_win  <= n_last_win;
            r_out_valid <= n_out_valid;
        end
        r_cwnd <= n_cwnd;
        r_ssth <= n_ssth;
        r_upd  <= n_upd;
        r_out  <= n_out;
    end

    // serial multiplier, shared by the window-end test and the window cut
    dcwe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_rsp   (w_mul)
    );

    // marked fraction divider
    dcwe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_marked),
        .i_den   (r_acked),
        .o_rsp   (w_div)
    );

`ifndef SYNTH
    // marked packets never outnumber acked ones, so the fraction stays within one
    a_marked_le_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_marked <= r_acked)
        else $error("marked count above acked count");

    // alpha never exceeds one
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha <= dcwe_pkg::ALPHA_ONE)
        else $error("alpha above one");

    // multiplier finishes only where the sequencer waits for it
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul.done |-> (r_state == dcwe_pkg::S_CMP_WAIT || r_state == dcwe_pkg::S_CUT_WAIT))
        else $error("multiplier done outside a wait state");

    // divider finishes only where the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == dcwe_pkg::S_DIV_WAIT))
        else $error("divider done outside its wait state");

    // a drop goes straight to the result
    a_drop_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == dcwe_pkg::REQ_DROP) |=> (r_state == dcwe_pkg::S_EMIT))
        else $error("drop item did not go to emit");
`endif

endmodule

@@ src/dcwe_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
module dcwe_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic      [dcwe_pkg::WIN_W-1:0]  i_a,
    input  logic      [dcwe_pkg::MUL_B_W-1:0] i_b,
    output dcwe_pkg::t_mul_rsp               o_rsp
);

    logic [dcwe_pkg::WIN_W-1:0]   r_a, n_a;
    logic [dcwe_pkg::MUL_B_W-1:0] r_b, n_b;
    logic [dcwe_pkg::PROD_W-1:0]  r_acc, n_acc;
    logic [dcwe_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;

    // one horner step per cycle
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_cnt  = dcwe_pkg::MUL_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = {r_acc[dcwe_pkg::PROD_W-2:0], 1'b0}
                  + (r_b[dcwe_pkg::MUL_B_W-1] ? dcwe_pkg::PROD_W'(r_a)
                                               : {dcwe_pkg::PROD_W{1'b0}});
            n_b   = {r_b[dcwe_pkg::MUL_B_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control with reset, datapath without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

@@ src/dcwe_div.sv @@
// restoring divider for the q16 marked fraction, one quotient bit per cycle
module dcwe_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic     [dcwe_pkg::CNT_W-1:0]  i_num,
    input  logic     [dcwe_pkg::CNT_W-1:0]  i_den,
    output dcwe_pkg::t_div_rsp              o_rsp
);

    logic [dcwe_pkg::CNT_W:0]    r_rem, n_rem;
    logic [dcwe_pkg::CNT_W-1:0]  r_den, n_den;
    logic [dcwe_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [dcwe_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                        r_first, n_first;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [dcwe_pkg::CNT_W:0]    w_trial;
    logic                        w_ge;

    // numerator never exceeds the denominator, so the remainder fits one extra bit
    assign w_trial = r_first ? r_rem : {r_rem[dcwe_pkg::CNT_W-1:0], 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // one compare and subtract per cycle
    always_comb begin
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
            n_quo   = '0;
            n_cnt   = dcwe_pkg::DIV_STEPS;
            n_first = 1'b1;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rem   = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            n_quo   = {r_quo[dcwe_pkg::QUO_W-2:0], w_ge};
            n_first = 1'b0;
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control with reset, datapath without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_first <= n_first;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the dctcp window estimator with its own alpha and window predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 120;
    localparam int REPORT_MAX  = 10;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    dcwe_pkg::t_req                 i_req;
    logic                           o_valid;
    logic                           i_ready;
    dcwe_pkg::t_rsp                 o_rsp;
    logic                           i_cfg_we;
    logic [dcwe_pkg::MSS_W-1:0]     i_cfg_data;

    // predictor state, mirrors the block after reset
    logic [dcwe_pkg::MSS_W-1:0]     mss_cfg;
    logic [dcwe_pkg::CNT_W-1:0]     acked_cnt;
    logic [dcwe_pkg::CNT_W-1:0]     marked_cnt;
    logic [dcwe_pkg::ALPHA_W-1:0]   alpha_q16;
    logic [dcwe_pkg::WIN_W-1:0]     win_mark;

    dcwe_pkg::t_rsp       expected_rsp_q[$];
    dcwe_pkg::t_rsp       want;
    int                   mismatches;
    int                   idle_cycles;
    int                   rx_hold_len;
    bit                   idle_on;
    int                   mark_pct;

    dctcp_window_estimator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // alpha estimate and window cut for one accepted item
    function automatic dcwe_pkg::t_rsp estimate_step(dcwe_pkg::t_req r);
        dcwe_pkg::t_rsp             res;
        logic [dcwe_pkg::WIN_W-1:0] cw;
        logic [dcwe_pkg::WIN_W-1:0] st;
        logic [dcwe_pkg::WIN_W-1:0] half;
        logic [dcwe_pkg::WIN_W-1:0] two_mss;
        logic [63:0]                frac;
        logic [63:0]                ewma;
        logic [63:0]                cut;
        cw = r.cwnd_in;
        st = r.ssthresh_in;
        res.window_update = 1'b0;
        if (r.req_type == dcwe_pkg::REQ_DROP) begin
            half = cw >> 1;
            two_mss = dcwe_pkg::WIN_W'(mss_cfg) << 1;
            acked_cnt = '0;
            marked_cnt = '0;
            st = (half > two_mss) ? half : two_mss;
            win_mark = cw;
        end else begin
            if (acked_cnt != dcwe_pkg::CNT_MAX) acked_cnt = acked_cnt + 1'b1;
            if (r.ece_flag) begin
                if (marked_cnt != dcwe_pkg::CNT_MAX) marked_cnt = marked_cnt + 1'b1;
                if (st > cw) st = cw;
            end
            // a window's worth of bytes acked
            if (64'(acked_cnt) * 64'(mss_cfg) >= 64'(win_mark)) begin
                frac = (64'(marked_cnt) << 16) / 64'(acked_cnt);
                if (frac > 64'(dcwe_pkg::ALPHA_ONE)) frac = 64'(dcwe_pkg::ALPHA_ONE);
                ewma = (64'(alpha_q16) * 64'd15 + frac) >> 4;
                if (ewma > 64'(dcwe_pkg::ALPHA_ONE)) ewma = 64'(dcwe_pkg::ALPHA_ONE);
                alpha_q16 = dcwe_pkg::ALPHA_W'(ewma);
                acked_cnt = '0;
                marked_cnt = '0;
                if (alpha_q16 != '0) begin
                    cut = (64'(cw) * (64'(dcwe_pkg::CUT_BASE) - 64'(alpha_q16))) >> 17;
                    cw = cut[dcwe_pkg::WIN_W-1:0];
                    if (cw < dcwe_pkg::WIN_W'(mss_cfg)) cw = dcwe_pkg::WIN_W'(mss_cfg);
                    st = cw;
                end
                win_mark = cw;
                res.window_update = 1'b1;
            end
        end
        res.cwnd_out = cw;
        res.ssthresh_out = st;
        res.alpha_out = alpha_q16;
        return res;
    endfunction

    // random item: mostly windows of a few segments, some full-range noise
    function automatic dcwe_pkg::t_req rand_req();
        dcwe_pkg::t_req r;
        int             pick;
        pick = $urandom_range(0, 99);
        r.req_type = (pick < 6) ? dcwe_pkg::REQ_DROP : dcwe_pkg::REQ_ACK;
        r.ece_flag = ($urandom_range(0, 99) < mark_pct);
        if (pick >= 92)
            r.cwnd_in = $urandom;
        else
            r.cwnd_in = dcwe_pkg::WIN_W'(mss_cfg) * $urandom_range(1, 12)
                        + $urandom_range(0, int'(mss_cfg));
        if ($urandom_range(0, 1) == 0)
            r.ssthresh_in = $urandom;
        else
            r.ssthresh_in = r.cwnd_in + $urandom_range(0, 4 * int'(mss_cfg))
                            - $urandom_range(0, 2 * int'(mss_cfg));
        return r;
    endfunction

    // sender gap with valid low, its length set by n
    task automatic pause_sender(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // offer one item, hold it until accepted, then record its expected result
    task automatic send_req(dcwe_pkg::t_req r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        expected_rsp_q.push_back(estimate_step(r));
        if (idle_on && $urandom_range(0, 7) == 0)
            pause_sender($urandom_range(1, 16));
    endtask

    task automatic send_fields(logic req, logic ecn, logic [dcwe_pkg::WIN_W-1:0] cw,
                               logic [dcwe_pkg::WIN_W-1:0] st);
        dcwe_pkg::t_req r;
        r.req_type = req;
        r.ece_flag = ecn;
        r.cwnd_in = cw;
        r.ssthresh_in = st;
        send_req(r);
    endtask

    // sender stops until every expected result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mss write while the block is idle
    task automatic write_mss(logic [dcwe_pkg::MSS_W-1:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mss_cfg = v;
    endtask

    // reset defaults: zero alpha at window end, ecn clamp, first cut, mss floor
    task automatic test_window_basics();
        send_fields(dcwe_pkg::REQ_ACK, 1'b0, 32'd3000, 32'd0);
        send_fields(dcwe_pkg::REQ_ACK, 1'b0, 32'd3000, 32'hFFFF_FFFF);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd3000, 32'd5000);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd3000, 32'd100);
        send_fields(dcwe_pkg::REQ_DROP, 1'b0, 32'd0, 32'd7);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd0, 32'hFFFF_FFFF);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(dcwe_pkg::REQ_ACK, 1'b0, 32'd40000, 32'd100);
    endtask

    // drops: ecn ignored, half window against the two segment floor
    task automatic test_drops();
        send_fields(dcwe_pkg::REQ_DROP, 1'b1, 32'hFFFF_FFFF, 32'd0);
        send_fields(dcwe_pkg::REQ_DROP, 1'b0, 32'd100, 32'hFFFF_FFFF);
        send_fields(dcwe_pkg::REQ_DROP, 1'b1, 32'd6001, 32'hAAAA_5555);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd6001, 32'h5555_AAAA);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd6001, 32'd6002);
        send_fields(dcwe_pkg::REQ_ACK, 1'b0, 32'd6001, 32'd6000);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd6001, 32'd6001);
    endtask

    // zero mss: window end only with a zero window mark, floors vanish
    task automatic test_zero_mss();
        write_mss('0);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd5000, 32'd9000);
        send_fields(dcwe_pkg::REQ_DROP, 1'b0, 32'd0, 32'd123);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd0, 32'd10);
        send_fields(dcwe_pkg::REQ_ACK, 1'b0, 32'd7, 32'd3);
        send_fields(dcwe_pkg::REQ_DROP, 1'b0, 32'd10, 32'd0);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd10, 32'd20);
    endtask

    // largest mss and a small mss of 64 written
    task automatic test_mss_extremes();
        write_mss(dcwe_pkg::MSS_W'(16383));
        send_fields(dcwe_pkg::REQ_DROP, 1'b0, 32'd32767, 32'd0);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd100, 32'd50000);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd100, 32'd50000);
        write_mss(dcwe_pkg::MSS_W'(64));
        send_fields(dcwe_pkg::REQ_DROP, 1'b1, 32'd200, 32'd1);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd200, 32'd300);
        send_fields(dcwe_pkg::REQ_ACK, 1'b1, 32'd200, 32'd300);
    endtask

    // random windows at one mss and marking rate
    task automatic test_random_flows(int n, logic [dcwe_pkg::MSS_W-1:0] mss_v, int pct);
        write_mss(mss_v);
        mark_pct = pct;
        repeat (n) send_req(rand_req());
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        drain_results();
        rx_hold_len = 300;
        repeat (30) begin
            @(negedge i_clk);
            i_valid <= 1'b1;
            i_req <= rand_req();
            do @(posedge i_clk); while (!o_ready);
            expected_rsp_q.push_back(estimate_step(i_req));
        end
        drain_results();
    endtask

    // receiver side: random stall bursts and one long hold on request
    initial begin : rx_side
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 16);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: cwnd %0d ssth %0d upd %0b alpha %0d",
                             o_rsp.cwnd_out, o_rsp.ssthresh_out,
                             o_rsp.window_update, o_rsp.alpha_out);
            end else begin
                want = expected_rsp_q.pop_front();
                if (o_rsp.cwnd_out !== want.cwnd_out
                        || o_rsp.ssthresh_out !== want.ssthresh_out
                        || o_rsp.window_update !== want.window_update
                        || o_rsp.alpha_out !== want.alpha_out) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: cwnd %0d/%0d ssth %0d/%0d upd %0b/%0b alpha %0d/%0d",
                                 want.cwnd_out, o_rsp.cwnd_out,
                                 want.ssthresh_out, o_rsp.ssthresh_out,
                                 want.window_update, o_rsp.window_update,
                                 want.alpha_out, o_rsp.alpha_out);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or taken result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        rx_hold_len = 0;
        idle_on = 1'b1;
        mark_pct = 30;
        mss_cfg = dcwe_pkg::MSS_RESET;
        acked_cnt = '0;
        marked_cnt = '0;
        alpha_q16 = '0;
        win_mark = dcwe_pkg::LAST_WIN_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_window_basics();
        test_drops();
        test_zero_mss();
        test_mss_extremes();
        test_random_flows(250, dcwe_pkg::MSS_RESET, 30);
        test_backpressure();
        test_random_flows(150, dcwe_pkg::MSS_W'(64), 80);
        test_random_flows(120, dcwe_pkg::MSS_W'(9000), 10);
        test_random_flows(80, dcwe_pkg::MSS_W'(16383), 50);
        test_random_flows(80, dcwe_pkg::MSS_W'($urandom_range(64, 9000)), 100);
        idle_on = 1'b0;
        test_random_flows(180, dcwe_pkg::MSS_W'($urandom_range(0, 16383)), 40);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
